// File: src/mptu_pkg.sv
// Package for the mip page table update block: field widths, reset values,
// register and request codes, sequencer states. No dependencies.
`default_nettype none

package mptu_pkg;

  localparam int unsigned WORD_W   = 16;  // table word
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned POS_W    = 5;   // page row / column
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned NODE_W   = 12;  // node coordinate below a page, 5 + 7 bits
  localparam int unsigned SUB_W    = 7;   // row / column offset inside a subtree
  localparam int unsigned CFG_W    = 16;  // widest config register
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [WORD_W-1:0] EMPTY_WORD = 16'hFFFF;

  localparam int unsigned DEF_TABLE_W    = 64;
  localparam int unsigned DEF_TABLE_H    = 64;
  localparam int unsigned DEF_MAX_LEVELS = 6;

  localparam logic [LEVEL_W-1:0] RESET_LEVEL_COUNT = 3'd6;
  localparam logic [WORD_W-1:0]  RESET_PAGE_STRIDE = 16'd512;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_STRIDE = 1'b1;

  localparam logic REQ_CACHE = 1'b0;
  localparam logic REQ_EJECT = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,  // reset sweep over the table
    S_IDLE,
    S_START,  // range checks, slot products, parent address
    S_PRL,    // parent reads: size, x, y
    S_PRX,
    S_PRY,
    S_PRD,
    S_NODE,   // address of the current descendant
    S_RDL,
    S_RDX,
    S_RDY,
    S_CHK,
    S_WRL,
    S_WRX,
    S_WRY,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// File: src/mip_page_table_update.sv
// Mip page table update: sequencer over a single-port indirection table.
// Depends on mptu_pkg.
`default_nettype none

// Usage
//   Requests come in on in_valid_i / in_stall_o with req_type_i, page_level_i,
//   page_row_i, page_col_i, slot_x_i, slot_y_i. One result per request leaves
//   on out_valid_o / out_stall_i with ignored_o and nodes_changed_o. Config
//   (level_count, page_stride) is written by the user through cfg_we_i,
//   cfg_index_i and cfg_data_i, one register per cycle, only while idle.
// Sequence
//   One request at a time: accept, setup, then for an eject whose parent lies
//   in the table the parent's size, x and y reads, then the subtree walk and
//   the result. Per subtree node: skipped when outside the grid; a cache
//   compares the size word and on a rewrite writes size, x and y; an eject
//   reads and compares size, x and y and on a match writes all three. The
//   table's single port, one read or one write a cycle, sets these steps.
// Reset
//   The table's TABLE_W*TABLE_H words are swept to 0xFFFF, one word a cycle;
//   in_stall_o stays high meanwhile. Config writes are taken at any time.
// Output stall
//   The result sits in an output register; the next request is accepted
//   while it waits, and its own result holds in the last state until the
//   register frees.

module mip_page_table_update
  import mptu_pkg::*;
#(
  parameter int unsigned TABLE_W    = DEF_TABLE_W,
  parameter int unsigned TABLE_H    = DEF_TABLE_H,
  parameter int unsigned MAX_LEVELS = DEF_MAX_LEVELS
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // config
  input  wire                   cfg_we_i,
  input  wire [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [CFG_W-1:0]       cfg_data_i,
  // request channel
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire                   req_type_i,
  input  wire [LEVEL_W-1:0]     page_level_i,
  input  wire [POS_W-1:0]       page_row_i,
  input  wire [POS_W-1:0]       page_col_i,
  input  wire [SLOT_W-1:0]      slot_x_i,
  input  wire [SLOT_W-1:0]      slot_y_i,
  // result channel
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic                  ignored_o,
  output logic [COUNT_W-1:0]    nodes_changed_o
);

  localparam int unsigned DEPTH = TABLE_W * TABLE_H;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = (TABLE_H > 1) ? $clog2(TABLE_H) : 1;
  localparam int unsigned CW    = (TABLE_W > 1) ? $clog2(TABLE_W) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // control
  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [LEVEL_W-1:0] level_count_q;
  logic [WORD_W-1:0]  page_stride_q;
  logic out_valid_q, out_valid_d;

  // request context
  logic               eject_q, eject_d;
  logic [LEVEL_W-1:0] d_q, d_d;
  logic [POS_W-1:0]   i_q, i_d, j_q, j_d;
  logic [SLOT_W-1:0]  sx_q, sx_d, sy_q, sy_d;
  logic [WORD_W-1:0]  nx_q, nx_d, ny_q, ny_d, nl_q, nl_d;
  logic [WORD_W-1:0]  px_q, px_d, py_q, py_d, pl_q, pl_d;
  logic [WORD_W-1:0]  xv_q, xv_d, lv_q, lv_d;
  logic [LEVEL_W-1:0] k_q, k_d;
  logic [SUB_W-1:0]   rr_q, rr_d, cc_q, cc_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [AW-1:0]      ax_q, ax_d, ay_q, ay_d, al_q, al_d;
  logic               ignored_q, ignored_d;
  logic [COUNT_W-1:0] res_count_q, res_count_d;

  // table
  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_re, mem_we;
  logic [AW-1:0]     mem_addr;
  logic [WORD_W-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  // effective level limit
  logic [3:0] top_c;
  always_comb begin
    if (4'(level_count_q) < 4'(MAX_LEVELS)) begin
      top_c = 4'(level_count_q);
    end else begin
      top_c = 4'(MAX_LEVELS);
    end
  end

  // subtree walk position
  logic [LEVEL_W-1:0] s_c;
  logic [SUB_W-1:0]   mask_c;
  assign s_c    = d_q - k_q;
  assign mask_c = SUB_W'((8'd1 << s_c) - 8'd1);

  // node address unit: parent during setup, current descendant otherwise
  logic [3:0]        lvl_c;
  logic [NODE_W-1:0] r_c, c_c, dr_c, dc_c, row_c, col_c, rowx_c;
  logic              grid_c;
  logic [AW-1:0]     ax_c, ay_c, al_c;

  always_comb begin
    if (state_q == S_START) begin
      lvl_c = 4'(d_q) + 4'd1;
      r_c   = NODE_W'(i_q >> 1);
      c_c   = NODE_W'(j_q >> 1);
    end else begin
      lvl_c = 4'(k_q);
      r_c   = (NODE_W'(i_q) << s_c) + NODE_W'(rr_q);
      c_c   = (NODE_W'(j_q) << s_c) + NODE_W'(cc_q);
    end
    dr_c   = NODE_W'(TABLE_H >> (int'(lvl_c) + 1));
    dc_c   = NODE_W'(TABLE_W >> (int'(lvl_c) + 1));
    grid_c = (r_c < dr_c) && (c_c < dc_c);
    row_c  = r_c + NODE_W'(TABLE_H) - (dr_c << 1);
    col_c  = c_c + NODE_W'(TABLE_W) - (dc_c << 1);
    rowx_c = row_c + dr_c;
    ay_c   = AW'(row_c[RW-1:0]) * AW'(TABLE_W) + AW'(col_c[CW-1:0]);
    ax_c   = AW'(rowx_c[RW-1:0]) * AW'(TABLE_W) + AW'(col_c[CW-1:0]);
    al_c   = ay_c + AW'(dc_c);
  end

  // page itself in range
  logic [NODE_W-1:0] own_dr_c, own_dc_c;
  logic              own_ok_c;
  assign own_dr_c = NODE_W'(TABLE_H >> (int'(d_q) + 1));
  assign own_dc_c = NODE_W'(TABLE_W >> (int'(d_q) + 1));
  assign own_ok_c = (4'(d_q) < top_c) && (NODE_W'(i_q) < own_dr_c)
                    && (NODE_W'(j_q) < own_dc_c);

  // replacement words
  logic [WORD_W-1:0] wx_c, wy_c, wl_c;
  assign wx_c = eject_q ? px_q : nx_q;
  assign wy_c = eject_q ? py_q : ny_q;
  assign wl_c = eject_q ? pl_q : nl_q;

  logic out_free_c;
  assign out_free_c = !out_valid_q || !out_stall_i;

  // next node of the walk; reused wherever a node finishes
  logic advance;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    eject_d     = eject_q;
    d_d         = d_q;
    i_d         = i_q;
    j_d         = j_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    nx_d        = nx_q;
    ny_d        = ny_q;
    nl_d        = nl_q;
    px_d        = px_q;
    py_d        = py_q;
    pl_d        = pl_q;
    xv_d        = xv_q;
    lv_d        = lv_q;
    k_d         = k_q;
    rr_d        = rr_q;
    cc_d        = cc_q;
    count_d     = count_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    al_d        = al_q;
    ignored_d   = ignored_q;
    res_count_d = res_count_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = al_q;
    mem_wdata   = wl_c;
    in_stall_o  = 1'b1;
    advance     = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = EMPTY_WORD;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          eject_d = req_type_i;
          d_d     = page_level_i;
          i_d     = page_row_i;
          j_d     = page_col_i;
          sx_d    = slot_x_i;
          sy_d    = slot_y_i;
          state_d = S_START;
        end
      end
      S_START: begin
        nx_d    = WORD_W'(24'(sx_q) * 24'(page_stride_q) + 24'd1);
        ny_d    = WORD_W'(24'(sy_q) * 24'(page_stride_q) + 24'd1);
        nl_d    = WORD_W'(1) << d_q;
        px_d    = EMPTY_WORD;
        py_d    = EMPTY_WORD;
        pl_d    = EMPTY_WORD;
        k_d     = d_q;
        rr_d    = '0;
        cc_d    = '0;
        count_d = '0;
        if (!own_ok_c) begin
          ignored_d = 1'b1;
          state_d   = S_DONE;
        end else if ((eject_q == REQ_EJECT) && (4'(d_q) + 4'd1 < top_c) && grid_c) begin
          ax_d    = ax_c;
          ay_d    = ay_c;
          al_d    = al_c;
          state_d = S_PRL;
        end else begin
          state_d = S_NODE;
        end
      end
      S_PRL: begin
        mem_re   = 1'b1;
        mem_addr = al_q;
        state_d  = S_PRX;
      end
      S_PRX: begin
        pl_d     = rdata_q;
        mem_re   = 1'b1;
        mem_addr = ax_q;
        state_d  = S_PRY;
      end
      S_PRY: begin
        px_d     = rdata_q;
        mem_re   = 1'b1;
        mem_addr = ay_q;
        state_d  = S_PRD;
      end
      S_PRD: begin
        py_d    = rdata_q;
        state_d = S_NODE;
      end
      S_NODE: begin
        if (grid_c) begin
          ax_d    = ax_c;
          ay_d    = ay_c;
          al_d    = al_c;
          state_d = S_RDL;
        end else begin
          advance = 1'b1;
        end
      end
      S_RDL: begin
        mem_re   = 1'b1;
        mem_addr = al_q;
        state_d  = S_RDX;
      end
      S_RDX: begin
        lv_d = rdata_q;
        if (eject_q == REQ_CACHE) begin
          if (rdata_q > nl_q) begin
            state_d = S_WRL;
          end else begin
            advance = 1'b1;
          end
        end else begin
          mem_re   = 1'b1;
          mem_addr = ax_q;
          state_d  = S_RDY;
        end
      end
      S_RDY: begin
        xv_d     = rdata_q;
        mem_re   = 1'b1;
        mem_addr = ay_q;
        state_d  = S_CHK;
      end
      S_CHK: begin
        if ((xv_q == nx_q) && (rdata_q == ny_q) && (lv_q == nl_q)) begin
          state_d = S_WRL;
        end else begin
          advance = 1'b1;
        end
      end
      S_WRL: begin
        mem_we    = 1'b1;
        mem_addr  = al_q;
        mem_wdata = wl_c;
        state_d   = S_WRX;
      end
      S_WRX: begin
        mem_we    = 1'b1;
        mem_addr  = ax_q;
        mem_wdata = wx_c;
        state_d   = S_WRY;
      end
      S_WRY: begin
        mem_we    = 1'b1;
        mem_addr  = ay_q;
        mem_wdata = wy_c;
        count_d   = count_q + COUNT_W'(1);
        advance   = 1'b1;
      end
      S_DONE: begin
        if (out_free_c) begin
          out_valid_d = 1'b1;
          res_count_d = count_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // walk order: level d down to 0, rows then columns of the subtree
    if (advance) begin
      ignored_d = 1'b0;
      state_d   = S_NODE;
      if (cc_q != mask_c) begin
        cc_d = cc_q + SUB_W'(1);
      end else begin
        cc_d = '0;
        if (rr_q != mask_c) begin
          rr_d = rr_q + SUB_W'(1);
        end else begin
          rr_d = '0;
          if (k_q == '0) begin
            state_d = S_DONE;
          end else begin
            k_d = k_q - LEVEL_W'(1);
          end
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_q         <= '0;
      out_valid_q   <= 1'b0;
      level_count_q <= RESET_LEVEL_COUNT;
      page_stride_q <= RESET_PAGE_STRIDE;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LEVEL_COUNT: level_count_q <= cfg_data_i[LEVEL_W-1:0];
          CFG_PAGE_STRIDE: page_stride_q <= cfg_data_i[WORD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    eject_q     <= eject_d;
    d_q         <= d_d;
    i_q         <= i_d;
    j_q         <= j_d;
    sx_q        <= sx_d;
    sy_q        <= sy_d;
    nx_q        <= nx_d;
    ny_q        <= ny_d;
    nl_q        <= nl_d;
    px_q        <= px_d;
    py_q        <= py_d;
    pl_q        <= pl_d;
    xv_q        <= xv_d;
    lv_q        <= lv_d;
    k_q         <= k_d;
    rr_q        <= rr_d;
    cc_q        <= cc_d;
    count_q     <= count_d;
    ax_q        <= ax_d;
    ay_q        <= ay_d;
    al_q        <= al_d;
    ignored_q   <= ignored_d;
    res_count_q <= res_count_d;
  end

  assign out_valid_o     = out_valid_q;
  assign nodes_changed_o = res_count_q;

  // ignored flag follows the result register
  logic res_ignored_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free_c) begin
      res_ignored_q <= ignored_q;
    end else if (state_q == S_START) begin
      res_ignored_q <= res_ignored_q;
    end
  end
  assign ignored_o = res_ignored_q;

endmodule

`default_nettype wire

// File: bench/mip_page_table_update_tb.sv
// Testbench for mip_page_table_update: cache and eject requests checked against
// an in-bench copy of the mip indirection table, under random input gaps and
// output stalls. Depends on mptu_pkg and the block under test.

module mip_page_table_update_tb;
  import mptu_pkg::*;

  localparam int unsigned TBL_W         = DEF_TABLE_W;
  localparam int unsigned TBL_H         = DEF_TABLE_H;
  localparam int unsigned TOP_LEVELS    = DEF_MAX_LEVELS;
  // Worst case is an eject rewrite over 1365 nodes plus stalls; the limit
  // covers ~200 such requests several times over.
  localparam int unsigned CYCLE_LIMIT   = 20_000_000;
  localparam int unsigned DRAIN_LIMIT   = 200_000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASE_ITEMS   = 25;

  typedef struct packed {
    logic                kind;   // REQ_CACHE / REQ_EJECT
    logic [LEVEL_W-1:0]  level;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic [SLOT_W-1:0]   sx;
    logic [SLOT_W-1:0]   sy;
  } page_req_t;

  localparam int unsigned REQ_BITS = $bits(page_req_t);

  typedef struct packed {
    logic                ignored;
    logic [COUNT_W-1:0]  changed;
  } update_res_t;

  // DUT-facing signals, all known from time zero
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_LEVEL_COUNT;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 req_type_i = REQ_CACHE;
  logic [LEVEL_W-1:0]   page_level_i = '0;
  logic [POS_W-1:0]     page_row_i = '0;
  logic [POS_W-1:0]     page_col_i = '0;
  logic [SLOT_W-1:0]    slot_x_i = '0;
  logic [SLOT_W-1:0]    slot_y_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 ignored_o;
  logic [COUNT_W-1:0]   nodes_changed_o;

  // Predictor state: table copy plus config shadow
  logic [WORD_W-1:0]    page_words [0:TBL_W*TBL_H-1];
  logic [LEVEL_W-1:0]   lvl_count_q = RESET_LEVEL_COUNT;
  logic [WORD_W-1:0]    stride_q = RESET_PAGE_STRIDE;

  update_res_t          pending_results [$];
  page_req_t            cached_pages [$];   // recent caches, reused as ejects
  logic                 quiet = 1'b0;       // no gaps or stalls when set
  int unsigned          mismatches = 0;
  int unsigned          results_seen = 0;
  int unsigned          cycles = 0;
  int unsigned          stall_cnt = 0;

  mip_page_table_update dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .page_level_i    (page_level_i),
    .page_row_i      (page_row_i),
    .page_col_i      (page_col_i),
    .slot_x_i        (slot_x_i),
    .slot_y_i        (slot_y_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ignored_o       (ignored_o),
    .nodes_changed_o (nodes_changed_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    foreach (page_words[a]) page_words[a] = EMPTY_WORD;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit in_grid(int unsigned d, int unsigned r, int unsigned c);
    return d < 16 && r < (TBL_H >> (d + 1)) && c < (TBL_W >> (d + 1));
  endfunction

  // Word addresses of a node's x, y and size entries. Each level is three
  // planes; level d nests inside the lower-right quadrant left by level d-1.
  function automatic void node_words(input int unsigned d, input int unsigned r,
                                     input int unsigned c, output int unsigned ax,
                                     output int unsigned ay, output int unsigned al);
    int unsigned dc, dr, wrow, wcol;
    dc   = TBL_W >> (d + 1);
    dr   = TBL_H >> (d + 1);
    wrow = r + TBL_H - 2 * dr;
    wcol = c + TBL_W - 2 * dc;
    ax   = (wrow + dr) * TBL_W + wcol;
    ay   = wrow * TBL_W + wcol;
    al   = ay + dc;
  endfunction

  // Applies one request to the table copy and returns the expected result.
  function automatic update_res_t apply_update(page_req_t rq);
    update_res_t res;
    int unsigned top, d, i, j, s, span, rr, cc, r, c, ax, ay, al, count, tmp;
    int          k;
    logic [WORD_W-1:0] nx, ny, nl, px, py, pl;
    res.ignored = 1'b1;
    res.changed = '0;
    top = (lvl_count_q < TOP_LEVELS) ? lvl_count_q : TOP_LEVELS;
    d = rq.level;
    i = rq.row;
    j = rq.col;
    if (d >= top || !in_grid(d, i, j)) return res;

    // slot products wrap to the word width
    tmp = rq.sx * stride_q + 1;
    nx  = tmp[WORD_W-1:0];
    tmp = rq.sy * stride_q + 1;
    ny  = tmp[WORD_W-1:0];
    tmp = 1 << d;
    nl  = tmp[WORD_W-1:0];

    // eject hands matching nodes the parent's triple, or empty at the top
    px = EMPTY_WORD;
    py = EMPTY_WORD;
    pl = EMPTY_WORD;
    if (rq.kind == REQ_EJECT && d + 1 < top && in_grid(d + 1, i >> 1, j >> 1)) begin
      node_words(d + 1, i >> 1, j >> 1, ax, ay, al);
      px = page_words[ax];
      py = page_words[ay];
      pl = page_words[al];
    end

    count = 0;
    for (k = int'(d); k >= 0; k--) begin
      s    = d - k;
      span = 1 << s;
      for (rr = 0; rr < span; rr++) begin
        for (cc = 0; cc < span; cc++) begin
          r = (i << s) + rr;
          c = (j << s) + cc;
          if (!in_grid(k, r, c)) continue;
          node_words(k, r, c, ax, ay, al);
          if (rq.kind == REQ_CACHE) begin
            if (page_words[al] > nl) begin
              page_words[al] = nl;
              page_words[ax] = nx;
              page_words[ay] = ny;
              count++;
            end
          end else if (page_words[ax] == nx && page_words[ay] == ny &&
                       page_words[al] == nl) begin
            // counts even when the replacement equals the old triple
            page_words[ax] = px;
            page_words[ay] = py;
            page_words[al] = pl;
            count++;
          end
        end
      end
    end
    res.ignored = 1'b0;
    res.changed = count[COUNT_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, and the checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
      stall_cnt   <= 0;
    end else if (stall_cnt != 0) begin
      out_stall_i <= 1'b1;
      stall_cnt   <= stall_cnt - 1;
    end else if ($urandom_range(0, 15) == 0) begin
      out_stall_i <= 1'b1;
      stall_cnt   <= $urandom_range(0, 17);  // random burst length
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic report_mismatch(string msg);
    $display("mismatch @%0d: %s", cycles, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_results
    update_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d with no request pending", results_seen));
      end else begin
        want = pending_results.pop_front();
        if (ignored_o !== want.ignored)
          report_mismatch($sformatf("result %0d ignored %b, want %b",
                                    results_seen, ignored_o, want.ignored));
        if (nodes_changed_o !== want.changed)
          report_mismatch($sformatf("result %0d nodes_changed %0d, want %0d",
                                    results_seen, nodes_changed_o, want.changed));
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  function automatic page_req_t page_req(logic kind, int unsigned level, int unsigned row,
                                         int unsigned col, int unsigned sx, int unsigned sy);
    page_req_t rq;
    rq.kind  = kind;
    rq.level = level[LEVEL_W-1:0];
    rq.row   = row[POS_W-1:0];
    rq.col   = col[POS_W-1:0];
    rq.sx    = sx[SLOT_W-1:0];
    rq.sy    = sy[SLOT_W-1:0];
    return rq;
  endfunction

  // Sends one request; valid stays high after acceptance so back-to-back
  // requests never lower and raise it in the same step.
  task automatic send_request(input page_req_t rq, output logic ign);
    update_res_t res;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= rq.kind;
    page_level_i <= rq.level;
    page_row_i   <= rq.row;
    page_col_i   <= rq.col;
    slot_x_i     <= rq.sx;
    slot_y_i     <= rq.sy;
    do @(posedge clk_i); while (in_stall_o);
    res = apply_update(rq);
    pending_results.push_back(res);
    ign = res.ignored;
  endtask

  task automatic send(page_req_t rq);
    logic ign;
    send_request(rq, ign);
  endtask

  // Sender holds off until every outstanding result has been taken.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic quiesce();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    if (idx == CFG_LEVEL_COUNT) lvl_count_q = data[LEVEL_W-1:0];
    else stride_q = data;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Block is idle before any register write; level_count gets junk above
  // its three bits.
  task automatic set_config(int unsigned lc, int unsigned stride);
    logic [CFG_W-1:0] v;
    quiesce();
    v = CFG_W'($urandom);
    v[LEVEL_W-1:0] = lc[LEVEL_W-1:0];
    write_reg(CFG_LEVEL_COUNT, v);
    write_reg(CFG_PAGE_STRIDE, stride[CFG_W-1:0]);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_cache_eject();
    set_config(6, 512);
    send(page_req(REQ_CACHE, 0, 0, 0, 0, 0));
    send(page_req(REQ_CACHE, 5, 0, 0, 255, 255));      // whole pyramid
    send(page_req(REQ_CACHE, 1, 15, 15, 1, 2));
    send(page_req(REQ_EJECT, 1, 15, 15, 1, 2));        // parent triple back
    send(page_req(REQ_EJECT, 5, 0, 0, 255, 255));      // top level, to empty
    send(page_req(REQ_EJECT, 0, 3, 3, 9, 9));          // nothing matches
    send(page_req(REQ_CACHE, 6, 0, 0, 4, 4));          // level out of range
    send(page_req(REQ_CACHE, 7, 31, 31, 255, 255));
    send(page_req(REQ_CACHE, 1, 16, 0, 1, 1));         // outside grid
    send(page_req(REQ_EJECT, 5, 0, 1, 1, 1));
    send(page_req(REQ_CACHE, 0, 31, 31, 200, 100));
    send(page_req(REQ_CACHE, 3, 3, 3, 0, 255));
    send(page_req(REQ_CACHE, 2, 7, 7, 255, 0));        // finer page wins below
    send(page_req(REQ_EJECT, 2, 7, 7, 255, 0));
    send(page_req(REQ_CACHE, 4, 1, 0, 128, 64));
    send(page_req(REQ_EJECT, 4, 1, 0, 128, 64));       // parent is empty
  endtask

  task automatic test_stride_wrap();
    set_config(6, 16'hFFFF);
    send(page_req(REQ_CACHE, 2, 4, 4, 255, 255));
    send(page_req(REQ_CACHE, 0, 5, 5, 255, 255));
    send(page_req(REQ_EJECT, 0, 5, 5, 255, 255));
    set_config(6, 0);                                  // stride 0: every slot maps to 1
    send(page_req(REQ_CACHE, 0, 6, 6, 17, 200));
    send(page_req(REQ_EJECT, 0, 6, 6, 0, 0));
  endtask

  task automatic test_level_limits();
    set_config(0, 512);                                // drops every request
    send(page_req(REQ_CACHE, 0, 0, 0, 1, 1));
    set_config(1, 512);
    send(page_req(REQ_CACHE, 0, 2, 2, 3, 3));
    send(page_req(REQ_EJECT, 0, 2, 2, 3, 3));          // level 0 is the top
    send(page_req(REQ_CACHE, 1, 0, 0, 3, 3));
    set_config(3, 512);
    send(page_req(REQ_CACHE, 2, 1, 1, 4, 4));
    send(page_req(REQ_EJECT, 2, 1, 1, 4, 4));
    set_config(7, 512);                                // clamps to six levels
    send(page_req(REQ_EJECT, 5, 0, 0, 1, 1));
    send(page_req(REQ_CACHE, 6, 0, 0, 1, 1));
  endtask

  // Mostly small levels; the top levels walk up to 1365 nodes each.
  function automatic logic [LEVEL_W-1:0] pick_level();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 30) return 3'd0;
    if (p < 55) return 3'd1;
    if (p < 72) return 3'd2;
    if (p < 84) return 3'd3;
    if (p < 91) return 3'd4;
    if (p < 94) return 3'd5;
    return LEVEL_W'($urandom_range(6, 7));
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(int unsigned grid);
    if (grid == 0 || $urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 31));
    return POS_W'($urandom_range(0, grid - 1));
  endfunction

  // Cache, then eject of the same page and slot, so ejects really match;
  // the rest is unrelated ejects and raw noise. Only requests the block
  // acts on count toward a phase.
  task automatic test_random();
    int unsigned phase, done, p, pick;
    page_req_t rq;
    logic ign;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_config(6, $urandom_range(1, 65535));
        1: set_config($urandom_range(2, 5), 1);
        2: set_config(7, 16'hFFFF);
        default: begin
          set_config(6, RESET_PAGE_STRIDE);
          quiet = 1'b1;
        end
      endcase
      cached_pages.delete();
      done = 0;
      while (done < PHASE_ITEMS) begin
        p = $urandom_range(0, 99);
        if (p >= 50 && p < 80 && cached_pages.size() != 0) begin
          pick = $urandom_range(0, cached_pages.size() - 1);
          rq = cached_pages[pick];
          cached_pages.delete(pick);
          rq.kind = REQ_EJECT;
        end else if (p >= 92) begin
          rq = REQ_BITS'($urandom);
        end else begin
          rq.kind  = (p >= 80) ? REQ_EJECT : REQ_CACHE;
          rq.level = pick_level();
          rq.row   = pick_pos(TBL_H >> (rq.level + 1));
          rq.col   = pick_pos(TBL_W >> (rq.level + 1));
          rq.sx    = SLOT_W'($urandom);
          rq.sy    = SLOT_W'($urandom);
        end
        send_request(rq, ign);
        if (!ign) begin
          done++;
          if (rq.kind == REQ_CACHE && cached_pages.size() < 32) cached_pages.push_back(rq);
          if (phase == 0 && done == PHASE_ITEMS / 2) wait_drained();
        end
      end
    end
  endtask

  initial begin : main
    int unsigned n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_cache_eject();
    test_stride_wrap();
    test_level_limits();
    test_random();

    in_valid_i <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && pending_results.size() != 0; n++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: mip_page_table_update.f
src/mptu_pkg.sv
src/mip_page_table_update.sv
bench/mip_page_table_update_tb.sv
